@@ design/lppd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_pkg
// Shared types and constants of the lidar packet point decoder.
// ----------------------------------------------------------------------------
package lppd_pkg;

  localparam logic [7:0]  HDR_FIRST      = 8'hAA;
  localparam logic [7:0]  HDR_SECOND     = 8'h55;
  localparam logic [14:0] FULL_TURN      = 15'd23040;
  localparam logic [15:0] HALF_TURN      = 16'd11520;
  localparam int          CORDIC_STEPS   = 18;
  localparam int          DIV_STEPS      = 31;
  localparam logic [15:0] MIN_DIST_RESET = 16'd40;

  // Parser phases.
  localparam logic [1:0] PH_HUNT1  = 2'd0;
  localparam logic [1:0] PH_HUNT2  = 2'd1;
  localparam logic [1:0] PH_HEADER = 2'd2;
  localparam logic [1:0] PH_SAMPLE = 2'd3;

  typedef struct packed {
    logic       load;
    logic       iter;
    logic [4:0] iter_idx;
    logic       sum;
    logic       modr;
    logic       emit;
  } lppd_cmd_t;

  typedef struct packed {
    logic hit;
    logic mod_done;
    logic out_free;
  } lppd_status_t;

  // atan(2^-k) in degrees times 16384.
  function automatic logic signed [23:0] atan_step(input logic [4:0] k);
    logic signed [23:0] v;
    case (k)
      5'd0:    v = 24'sd737280;
      5'd1:    v = 24'sd435242;
      5'd2:    v = 24'sd229970;
      5'd3:    v = 24'sd116736;
      5'd4:    v = 24'sd58595;
      5'd5:    v = 24'sd29326;
      5'd6:    v = 24'sd14667;
      5'd7:    v = 24'sd7334;
      5'd8:    v = 24'sd3667;
      5'd9:    v = 24'sd1833;
      5'd10:   v = 24'sd917;
      5'd11:   v = 24'sd458;
      5'd12:   v = 24'sd229;
      5'd13:   v = 24'sd115;
      5'd14:   v = 24'sd57;
      5'd15:   v = 24'sd29;
      5'd16:   v = 24'sd14;
      5'd17:   v = 24'sd7;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

@@ design/lppd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_ctrl
// Sequencer for one point: operand load, shared divide/CORDIC iterations,
// final sum, modulo reduction and handoff to the output register.
// ----------------------------------------------------------------------------
module lppd_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  lppd_pkg::lppd_status_t status,
  output lppd_pkg::lppd_cmd_t    cmd,
  output logic                   busy
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_ITER = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_MOD  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  localparam logic [4:0] LAST_ITER = 5'(lppd_pkg::DIV_STEPS - 1);

  logic [2:0] state, state_next;
  logic [4:0] iter, iter_next;

  always_comb begin
    state_next = state;
    iter_next  = iter;
    cmd        = '0;
    cmd.iter_idx = iter;
    case (state)
      ST_IDLE: begin
        if (accept && status.hit) begin
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        iter_next  = '0;
        state_next = ST_ITER;
      end
      ST_ITER: begin
        cmd.iter  = 1'b1;
        iter_next = iter + 5'd1;
        if (iter == LAST_ITER) begin
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MOD;
      end
      ST_MOD: begin
        cmd.modr = 1'b1;
        if (status.mod_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      iter  <= '0;
    end else begin
      state <= state_next;
      iter  <= iter_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ design/lppd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_dp
// Byte parser, serial divider, CORDIC unit, modulo reduction and output
// register of the point decoder.
// ----------------------------------------------------------------------------
module lppd_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [7:0]             rx_byte,
  input  logic [15:0]            min_distance_raw,
  input  lppd_pkg::lppd_cmd_t    cmd,
  output lppd_pkg::lppd_status_t status,
  input  logic                   out_stall,
  output logic                   out_valid,
  output logic [14:0]            point_angle,
  output logic [15:0]            point_distance,
  output logic                   revolution_wrap,
  output logic                   earlier_wrap_seen
);

  // Parser state.
  logic [1:0]  phase;
  logic [2:0]  hdr_pos;
  logic [1:0]  sub;
  logic [7:0]  idx;
  logic [7:0]  sample_count;
  logic [14:0] start_angle;
  logic [14:0] end_angle;
  logic [7:0]  distance_low;
  logic [14:0] previous_angle;
  logic        wrap_seen;

  // Point operands.
  logic [15:0] raw;
  logic [7:0]  pidx;
  logic        multi;
  logic        neg;
  logic [7:0]  divisor;
  logic [30:0] dvd;
  logic [7:0]  remv;
  logic signed [33:0] cx, cy;
  logic signed [23:0] cz;
  logic [16:0] ang;

  logic [15:0] raw_now;
  logic        last_byte;

  assign raw_now   = {rx_byte, distance_low};
  assign last_byte = (sub == 2'd2) && (idx == sample_count - 8'd1);
  assign status.hit = (phase == lppd_pkg::PH_SAMPLE) && (sub == 2'd1)
                      && (raw_now > min_distance_raw);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= lppd_pkg::PH_HUNT1;
      hdr_pos        <= '0;
      sub            <= '0;
      idx            <= '0;
      sample_count   <= '0;
      start_angle    <= '0;
      end_angle      <= '0;
      distance_low   <= '0;
    end else if (accept) begin
      case (phase)
        lppd_pkg::PH_HUNT1: begin
          if (rx_byte == lppd_pkg::HDR_FIRST) begin
            phase <= lppd_pkg::PH_HUNT2;
          end
        end
        lppd_pkg::PH_HUNT2: begin
          if (rx_byte == lppd_pkg::HDR_SECOND) begin
            phase   <= lppd_pkg::PH_HEADER;
            hdr_pos <= 3'd2;
          end else if (rx_byte != lppd_pkg::HDR_FIRST) begin
            phase <= lppd_pkg::PH_HUNT1;
          end
        end
        lppd_pkg::PH_HEADER: begin
          case (hdr_pos)
            3'd3:         sample_count <= rx_byte;
            3'd4, 3'd6:   distance_low <= rx_byte;
            3'd5:         start_angle  <= raw_now[15:1];
            3'd7:         end_angle    <= raw_now[15:1];
            default:      ;
          endcase
          if (hdr_pos == 3'd7) begin
            phase <= (sample_count == 8'd0) ? lppd_pkg::PH_HUNT1 : lppd_pkg::PH_SAMPLE;
            sub   <= '0;
            idx   <= '0;
          end else begin
            hdr_pos <= hdr_pos + 3'd1;
          end
        end
        default: begin
          if (sub == 2'd0) begin
            distance_low <= rx_byte;
          end
          if (last_byte) begin
            phase <= lppd_pkg::PH_HUNT1;
          end else if (sub == 2'd2) begin
            sub <= '0;
            idx <= idx + 8'd1;
          end else begin
            sub <= sub + 2'd1;
          end
        end
      endcase
    end
  end

  // Operand capture at the distance high byte.
  always_ff @(posedge clk) begin
    if (accept && status.hit) begin
      raw  <= raw_now;
      pidx <= idx;
    end
  end

  // Load: span times sample index, and CORDIC start vector.
  logic signed [16:0] diff_raw, diff;
  logic signed [25:0] prod;
  logic [25:0]        prod_mag;
  logic signed [33:0] raw_s;

  assign diff_raw = $signed({2'b00, end_angle}) - $signed({2'b00, start_angle});
  assign diff     = diff_raw[16] ? diff_raw + $signed({2'b00, lppd_pkg::FULL_TURN})
                                 : diff_raw;
  assign prod     = $signed(26'(diff)) * $signed(26'({1'b0, pidx}));
  assign prod_mag = prod[25] ? 26'(-prod) : prod;
  assign raw_s    = $signed({18'd0, raw});

  // Shared iteration datapath.
  logic [8:0]         trial;
  logic               qbit;
  logic signed [33:0] xsh, ysh;
  logic [4:0]         k;

  assign k     = cmd.iter_idx;
  assign trial = {remv, dvd[30]};
  assign qbit  = (trial >= {1'b0, divisor});
  assign xsh   = cx >>> k;
  assign ysh   = cy >>> k;

  // Sum of base angle, interpolation and correction.
  logic signed [26:0] q_s, total;
  logic [25:0]        q_mag;

  assign q_mag = dvd[25:0] + {25'd0, (remv != 8'd0) && neg};
  assign q_s   = !multi ? 27'sd0 : (neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag}));
  assign total = $signed({4'd0, start_angle, 8'd0}) + q_s + 27'(cz)
                 + 27'sd5898368;

  assign status.mod_done = (ang < {2'b00, lppd_pkg::FULL_TURN});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg     <= prod[25];
      multi   <= (sample_count > 8'd1);
      divisor <= sample_count - 8'd1;
      dvd     <= {prod_mag[22:0], 8'd0};
      remv    <= '0;
      cx      <= 34'sd15530 * raw_s;
      cy      <= 34'sd218 * (34'sd6212 - 34'sd10 * raw_s);
      cz      <= '0;
    end else if (cmd.iter) begin
      remv <= qbit ? 8'(trial - {1'b0, divisor}) : trial[7:0];
      dvd  <= {dvd[29:0], qbit};
      if (k < 5'(lppd_pkg::CORDIC_STEPS)) begin
        if (!cy[33]) begin
          cx <= cx + ysh;
          cy <= cy - xsh;
          cz <= cz + lppd_pkg::atan_step(k);
        end else begin
          cx <= cx - ysh;
          cy <= cy + xsh;
          cz <= cz - lppd_pkg::atan_step(k);
        end
      end
    end
    if (cmd.sum) begin
      ang <= total[24:8];
    end else if (cmd.modr && !status.mod_done) begin
      ang <= ang - {2'b00, lppd_pkg::FULL_TURN};
    end
  end

  // Output register and revolution tracking.
  logic wrap;
  assign wrap = ({1'b0, previous_angle} > ({1'b0, ang[14:0]} + lppd_pkg::HALF_TURN));
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      previous_angle <= '0;
      wrap_seen      <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid      <= 1'b1;
        previous_angle <= ang[14:0];
        if (wrap) begin
          wrap_seen <= 1'b1;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      point_angle       <= ang[14:0];
      point_distance    <= raw;
      revolution_wrap   <= wrap;
      earlier_wrap_seen <= wrap && wrap_seen;
    end
  end

endmodule

@@ design/lidar_packet_point_decoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_point_decoder_core
// Decodes a lidar serial byte stream into corrected scan points.
// ----------------------------------------------------------------------------
// One received byte is one input transfer. Bytes that produce no point are
// taken without stalling the input. The distance high byte of a sample whose raw
// distance exceeds min_distance_raw starts a point computation, and the input
// holds stall through the load step, the iterations of the bit-serial
// divider that interpolates the sample angle (the 18-step CORDIC for the
// distance correction runs alongside it), the sum step, the modulo
// reduction and the handoff of the point to the output register. The
// output register parts both sides, so a finished point may wait for its
// transfer while later bytes are parsed; a next point waits only if the
// previous one has still not been taken. Angles are in 1/64 degree, 0..23039.
// Register min_distance_raw sits at byte address 0 of the APB port.
// ----------------------------------------------------------------------------
module lidar_packet_point_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] point_angle,
  output logic [15:0] point_distance,
  output logic        revolution_wrap,
  output logic        earlier_wrap_seen
);

  logic [15:0]            min_distance_raw;
  logic                   accept;
  logic                   busy;
  lppd_pkg::lppd_cmd_t    cmd;
  lppd_pkg::lppd_status_t status;

  // Configuration register; only the first word is decoded.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, min_distance_raw} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_distance_raw <= lppd_pkg::MIN_DIST_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == 1'b0)) begin
      min_distance_raw <= pwdata[15:0];
    end
  end

  // The parser only moves while the sequencer is idle.
  assign in_stall = busy;
  assign accept   = in_valid && !in_stall;

  lppd_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  lppd_dp u_dp (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .rx_byte           (rx_byte),
    .min_distance_raw  (min_distance_raw),
    .cmd               (cmd),
    .status            (status),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .point_angle       (point_angle),
    .point_distance    (point_distance),
    .revolution_wrap   (revolution_wrap),
    .earlier_wrap_seen (earlier_wrap_seen)
  );

endmodule

@@ design/lppd_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lppd_checker
// Port-level checks of the point decoder, bound to the top level.
// ----------------------------------------------------------------------------
module lppd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [14:0] point_angle,
  input logic        revolution_wrap,
  input logic        earlier_wrap_seen
);

  // A stalled point keeps its angle.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_angle))
    else $error("stalled point changed");

  // Angles are folded into one turn.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> point_angle < 15'd23040)
    else $error("angle out of range");

  // The full-scan flag only comes with a wrap.
  a_earlier: assert property (@(posedge clk) disable iff (rst)
    out_valid && !revolution_wrap |-> !earlier_wrap_seen)
    else $error("earlier wrap without wrap");

  // Reset empties the output register.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind lidar_packet_point_decoder_core lppd_checker u_lppd_checker (
  .clk               (clk),
  .rst               (rst),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .point_angle       (point_angle),
  .revolution_wrap   (revolution_wrap),
  .earlier_wrap_seen (earlier_wrap_seen)
);

@@ test/lidar_packet_point_decoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_point_decoder_checker
// Watches the byte and point channels and the APB port, predicts each point
// from its own copy of the parser state and compares it with the block.
// ----------------------------------------------------------------------------
module lidar_packet_point_decoder_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [14:0] point_angle,
  input  logic [15:0] point_distance,
  input  logic        revolution_wrap,
  input  logic        earlier_wrap_seen,
  output int          errors,
  output int          pending
);

  localparam int FULL = 23040;
  localparam int HALF = 11520;

  typedef struct {
    logic [14:0] angle;
    logic [15:0] distance;
    logic        wrap;
    logic        earlier;
  } scan_point_t;

  // atan(2^-k) in degrees, scaled by 16384.
  localparam longint ATAN_LUT [18] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334, 3667,
    1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  scan_point_t expected_points[$];

  logic [15:0] min_dist;
  logic [1:0]  phase;
  logic [9:0]  pos;
  logic [7:0]  count;
  logic [14:0] ang_start;
  logic [14:0] ang_end;
  logic [7:0]  low_byte;
  logic [14:0] last_angle;
  logic        wrapped_before;

  function automatic longint dist_correction(input logic [15:0] raw);
    longint x, y, z, nx;
    z = 0;
    if (raw == 0) return 0;
    x = 15530 * longint'(raw);
    y = 218 * (6212 - 10 * longint'(raw));
    for (int k = 0; k < 18; k++) begin
      if (y >= 0) begin
        nx = x + (y >>> k);
        y  = y - (x >>> k);
        z += ATAN_LUT[k];
      end else begin
        nx = x - (y >>> k);
        y  = y + (x >>> k);
        z -= ATAN_LUT[k];
      end
      x = nx;
    end
    return z;
  endfunction

  // Division rounded toward minus infinity.
  function automatic longint div_floor(input longint n, input longint d);
    longint q;
    q = n / d;
    if (n < 0 && (n % d) != 0) q--;
    return q;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic parse_byte(input logic [7:0] b);
    int unsigned rel, idx, sub;
    logic [15:0] raw;
    longint base, diff, total;
    int ang;
    scan_point_t p;
    case (phase)
      lppd_pkg::PH_HUNT1: if (b == lppd_pkg::HDR_FIRST) phase = lppd_pkg::PH_HUNT2;
      lppd_pkg::PH_HUNT2: begin
        if (b == lppd_pkg::HDR_SECOND) begin
          phase = lppd_pkg::PH_HEADER;
          pos = 2;
        end else if (b != lppd_pkg::HDR_FIRST) begin
          phase = lppd_pkg::PH_HUNT1;
        end
      end
      lppd_pkg::PH_HEADER: begin
        if (pos == 3) count = b;
        else if (pos == 4 || pos == 6) low_byte = b;
        else if (pos == 5) ang_start = 15'({b, low_byte} >> 1);
        else if (pos == 7) ang_end = 15'({b, low_byte} >> 1);
        if (pos >= 7) begin
          phase = (count == 0) ? lppd_pkg::PH_HUNT1 : lppd_pkg::PH_SAMPLE;
          pos = 8;
        end else begin
          pos++;
        end
      end
      default: begin
        rel = pos - 8;
        idx = rel / 3;
        sub = rel % 3;
        if (sub == 0) begin
          low_byte = b;
        end else if (sub == 1) begin
          raw = {b, low_byte};
          if (raw > min_dist) begin
            base = longint'(ang_start) * 256;
            if (count > 1) begin
              diff = longint'(ang_end) - longint'(ang_start);
              if (diff < 0) diff += FULL;
              base += div_floor(diff * longint'(idx) * 256, longint'(count) - 1);
            end
            total = base + dist_correction(raw) + longint'(FULL) * 256 + 128;
            ang = int'((total >>> 8) % FULL);
            p.angle = 15'(ang);
            p.distance = raw;
            p.wrap = (int'(last_angle) > ang + HALF);
            p.earlier = 1'b0;
            if (p.wrap) begin
              p.earlier = wrapped_before;
              wrapped_before = 1'b1;
            end
            last_angle = 15'(ang);
            expected_points = {expected_points, p};
          end
        end
        if (int'(pos) >= 7 + 3 * int'(count)) begin
          phase = lppd_pkg::PH_HUNT1;
          pos = 0;
        end else begin
          pos = pos + 10'd1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    scan_point_t w;
    if (rst) begin
      errors = 0;
      min_dist = lppd_pkg::MIN_DIST_RESET;
      phase = lppd_pkg::PH_HUNT1;
      pos = 0;
      count = 0;
      ang_start = 0;
      ang_end = 0;
      low_byte = 0;
      last_angle = 0;
      wrapped_before = 0;
      expected_points.delete();
    end else begin
      if (psel && penable && pwrite && pready && (paddr >> 2) == 0)
        min_dist = pwdata[15:0];
      if (in_valid && !in_stall)
        parse_byte(rx_byte);
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          report("unexpected point, angle", point_angle, -1);
        end else begin
          w = expected_points.pop_front();
          if (point_angle !== w.angle) report("point_angle", point_angle, w.angle);
          if (point_distance !== w.distance)
            report("point_distance", point_distance, w.distance);
          if (revolution_wrap !== w.wrap)
            report("revolution_wrap", revolution_wrap, w.wrap);
          if (earlier_wrap_seen !== w.earlier)
            report("earlier_wrap_seen", earlier_wrap_seen, w.earlier);
        end
      end
    end
    pending = expected_points.size();
  end

endmodule

@@ test/lidar_packet_point_decoder_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_packet_point_decoder_core_tb
// Feeds lidar byte streams to the decoder under several distance thresholds
// and lets the checker compare every emitted point.
// ----------------------------------------------------------------------------
module lidar_packet_point_decoder_core_tb;

  localparam int CYCLE_LIMIT = 1000000;
  // Settling time after the last expected point; it outlasts a point computation inside the block.
  localparam int DRAIN_CYCLES = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] point_angle;
  logic [15:0] point_distance;
  logic        revolution_wrap;
  logic        earlier_wrap_seen;

  int errors;
  int pending;
  int cycles = 0;
  int bytes_sent = 0;
  int hold_requests = 0;
  int holds_done = 0;
  logic [15:0] threshold = lppd_pkg::MIN_DIST_RESET;

  always #2 clk = ~clk;

  lidar_packet_point_decoder_core DUT (.*);

  lidar_packet_point_decoder_checker u_checker (.*);

  // Watchdog: a run that stalls forever ends here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver side. It stalls at random, sometimes in long runs, and serves a
  // long hold-off whenever the stimulus asks for one so the block backs up.
  initial begin
    int n;
    forever begin
      if (hold_requests != holds_done) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        holds_done++;
      end
      n = $urandom_range(0, 99);
      if (n < 10) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(10, 50)) @(posedge clk);
      end else if (n < 40) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        @(posedge clk);
      end
    end
  end

  // One byte transfer, sometimes followed by an idle gap that is mostly short.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_byte <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
        : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Registers change only once every point is out and the pipeline is empty.
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Raw distance: around the threshold, the extremes, or anything.
  function automatic logic [15:0] pick_distance();
    int n;
    n = $urandom_range(0, 9);
    if (n == 0) return 16'd0;
    if (n == 1) return 16'hFFFF;
    if (n == 2) return threshold;
    if (n == 3) return threshold + 16'd1;
    if (n < 6) return 16'($urandom_range(0, 3000));
    return 16'($urandom_range(0, 65535));
  endfunction

  // A whole packet; keep_bytes below the full length cuts it short.
  task automatic send_packet(input logic [7:0] samples, input logic [15:0] a_start,
                             input logic [15:0] a_end, input int keep_bytes);
    logic [7:0] pkt[$];
    logic [15:0] d;
    pkt = '{lppd_pkg::HDR_FIRST, lppd_pkg::HDR_SECOND, 8'($urandom_range(0, 255)),
            samples, a_start[7:0], a_start[15:8], a_end[7:0], a_end[15:8]};
    for (int i = 0; i < samples; i++) begin
      d = pick_distance();
      pkt = {pkt, d[7:0], d[15:8], 8'($urandom_range(0, 255))};
    end
    foreach (pkt[i]) if (i < keep_bytes) send_byte(pkt[i]);
  endtask

  // Mostly well-formed packets with random content, plus noise and cut packets.
  task automatic random_traffic(input int n_bytes);
    int stop_at;
    int n;
    int full_len;
    logic [7:0] s;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      n = $urandom_range(0, 19);
      s = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 2))
                                       : 8'($urandom_range(3, 12));
      full_len = 8 + 3 * s;
      if (n < 2) begin
        send_byte(8'($urandom_range(0, 255)));
      end else if (n < 4) begin
        send_packet(s, 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                    $urandom_range(1, full_len));
      end else begin
        send_packet(s, 16'($urandom_range(0, 46079)), 16'($urandom_range(0, 46079)),
                    full_len);
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: hunt noise, a repeated first header byte, a single
    // sample packet, an empty packet, a start above the end and out-of-range
    // angles.
    send_byte(8'h00);
    send_byte(lppd_pkg::HDR_FIRST);
    send_byte(8'h13);
    send_byte(lppd_pkg::HDR_FIRST);
    send_packet(8'd1, 16'd1000, 16'd1000, 11);
    send_packet(8'd0, 16'd200, 16'd400, 8);
    send_packet(8'd2, 16'd44000, 16'd600, 14);
    send_packet(8'd2, 16'hFFFF, 16'hFFFE, 14);
    drain_and_settle();

    random_traffic(50);
    drain_and_settle();

    // Every distance above zero passes; also poke an unmapped address.
    apb_write(3'd4, 32'd7);
    apb_write(3'd0, 32'd0);
    threshold = 16'd0;
    random_traffic(40);
    // Long receiver hold-off while packets keep coming.
    hold_requests++;
    send_packet(8'd12, 16'd100, 16'd20000, 44);
    random_traffic(20);
    drain_and_settle();

    // Nothing passes the top threshold, then a maximum-count packet cut short.
    apb_write(3'd0, 32'hFFFF);
    threshold = 16'hFFFF;
    random_traffic(20);
    drain_and_settle();
    apb_write(3'd0, 32'd1200);
    threshold = 16'd1200;
    send_packet(8'd255, 16'($urandom_range(0, 46079)), 16'($urandom_range(0, 46079)),
                200);
    drain_and_settle();

    threshold = 16'($urandom_range(0, 8000));
    apb_write(3'd0, {16'd0, threshold});
    random_traffic(30);
    drain_and_settle();

    apb_write(3'd0, 32'd40);
    threshold = 16'd40;
    random_traffic(20);
    drain_and_settle();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
